### src/byte_ring_fifo_with_skip_assert.svh
// Assertion macros for the byte ring FIFO with skip.
`ifndef BYTE_RING_FIFO_WITH_SKIP_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_SKIP_ASSERT_SVH

`ifndef SYNTHESIS

// Condition must never hold outside reset.
`define BRFIFO_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("byte ring fifo: forbidden condition seen");

// Antecedent in one cycle implies consequent in the next.
`define BRFIFO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("byte ring fifo: next-cycle check failed");

`else

`define BRFIFO_ASSERT_NEVER(label, clk, rst, cond)
`define BRFIFO_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### src/brfifo_pkg.sv
// Shared types and codes for the byte ring FIFO with skip.
`default_nettype none

package brfifo_pkg;

  // Default ring depth in bytes
  localparam int BRFIFO_DEPTH = 32;

  // Operation codes carried in the kind field
  localparam logic [2:0] KIND_PUSH  = 3'd0;
  localparam logic [2:0] KIND_POP   = 3'd1;
  localparam logic [2:0] KIND_PEEK  = 3'd2;
  localparam logic [2:0] KIND_SKIP  = 3'd3;
  localparam logic [2:0] KIND_FLUSH = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_WR_OFF   = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_TOO_FEW  = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_in;
    logic [5:0] skip_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_out;
    logic [5:0] fill_level;
    logic       overflow_flag;
  } out_item_t;

endpackage

`default_nettype wire

### src/brfifo_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module brfifo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/byte_ring_fifo_with_skip.sv
// Byte ring FIFO with push, pop, peek, skip and flush operations.
//
// Operations arrive on the in channel (in_valid / in_stall / in_data) and
// each one produces exactly one result on the out channel (out_valid /
// out_stall / out_data) carrying status, a data byte, the fill level after
// the operation and the sticky overflow flag.
// The write_enable register is written through cfg_valid / cfg_ready /
// cfg_data; cfg_ready is always high. Write it only while the block is idle.
// Timing: an operation is decided in the cycle of its transfer; pointers and
// count update at that edge, where the ring RAM read data and the middle
// stage also load. The result register loads from the middle stage when it
// is free or being taken, and out_valid then rises. Throughput is one
// operation per cycle while out_stall does not hold the pipeline; each
// operation does at most one RAM read or one RAM write.
// Reset clears pointers, count, overflow flag, write_enable (to 1) and the
// pipeline. Never-written bytes read as zero through a written-span counter
// cleared by flush and reset, so no clearing pass is needed.
// When out_stall holds a waiting result, the middle stage holds its item and
// in_stall rises while it is full; nothing is dropped.
`default_nettype none

`include "byte_ring_fifo_with_skip_assert.svh"

module byte_ring_fifo_with_skip
  import brfifo_pkg::*;
#(
  parameter int DEPTH = BRFIFO_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;
  localparam int SW   = ((AW + 1) > 6) ? (AW + 1) : 6;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  // Architectural state
  logic [AW-1:0] write_pointer, write_pointer_next;
  logic [AW-1:0] read_pointer, read_pointer_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] span, span_next;
  logic          error_sticky, error_sticky_next;
  logic          write_enable;

  // Middle stage
  logic          s1_valid;
  logic [1:0]    s1_status;
  logic [CW-1:0] s1_fill;
  logic          s1_flag;
  logic          s1_use_ram;

  // Per-operation decode
  logic          accept;
  logic          s1_go;
  logic [1:0]    status;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [AW-1:0] wp_inc;
  logic [AW-1:0] rp_inc;
  logic [SW-1:0] skip_sum;
  logic [AW-1:0] rp_skip;
  logic          too_few;

  assign cfg_ready = 1'b1;

  // Middle stage moves on when the result register is free or being taken
  assign s1_go    = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign accept   = in_valid && !in_stall;

  // Pointer arithmetic with wraparound
  assign wp_inc   = (write_pointer == LAST_A) ? '0 : write_pointer + 1'b1;
  assign rp_inc   = (read_pointer == LAST_A) ? '0 : read_pointer + 1'b1;
  assign skip_sum = SW'(read_pointer) + SW'(in_data.skip_count);
  assign rp_skip  = (skip_sum >= DEPTH_S) ? AW'(skip_sum - DEPTH_S) : AW'(skip_sum);
  assign too_few  = CMPW'(count) < CMPW'(in_data.skip_count);

  // Decide the operation against current state
  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    count_next         = count;
    span_next          = span;
    error_sticky_next  = error_sticky;
    status             = STATUS_OK;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    ram_raddr          = read_pointer;
    case (in_data.kind)
      KIND_PUSH: begin
        if (!write_enable) begin
          status = STATUS_WR_OFF;
        end else if (count >= DEPTH_C) begin
          status            = STATUS_FULL;
          error_sticky_next = 1'b1;
        end else begin
          ram_we             = 1'b1;
          write_pointer_next = wp_inc;
          count_next         = count + 1'b1;
          span_next          = (span == DEPTH_C) ? span : span + 1'b1;
        end
      end
      KIND_POP: begin
        if (count == '0) begin
          status            = STATUS_TOO_FEW;
          error_sticky_next = 1'b1;
        end else begin
          ram_re            = 1'b1;
          read_pointer_next = rp_inc;
          count_next        = count - 1'b1;
        end
      end
      KIND_PEEK: begin
        if (count == '0) begin
          status            = STATUS_TOO_FEW;
          error_sticky_next = 1'b1;
        end else begin
          ram_re = 1'b1;
        end
      end
      KIND_SKIP: begin
        if (too_few) begin
          status            = STATUS_TOO_FEW;
          error_sticky_next = 1'b1;
        end else begin
          ram_re            = 1'b1;
          ram_raddr         = rp_skip;
          read_pointer_next = rp_skip;
          count_next        = count - CW'(in_data.skip_count);
        end
      end
      KIND_FLUSH: begin
        write_pointer_next = '0;
        read_pointer_next  = '0;
        count_next         = '0;
        span_next          = '0;
      end
      default: begin
      end
    endcase
  end

  // Ring storage
  brfifo_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && ram_we),
    .waddr (write_pointer),
    .wdata (in_data.data_in),
    .re    (accept && ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hold state and write_enable; advance on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      count         <= '0;
      span          <= '0;
      error_sticky  <= 1'b0;
      write_enable  <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        write_enable <= cfg_data;
      end
      if (accept) begin
        write_pointer <= write_pointer_next;
        read_pointer  <= read_pointer_next;
        count         <= count_next;
        span          <= span_next;
        error_sticky  <= error_sticky_next;
      end
    end
  end

  // Middle stage: control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Middle stage: payload; bytes beyond the written span read as zero
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status  <= status;
      s1_fill    <= count_next;
      s1_flag    <= error_sticky_next;
      s1_use_ram <= ram_re && (CMPW'(ram_raddr) < CMPW'(span));
    end
  end

  // Result register: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data.status        <= s1_status;
      out_data.data_out      <= s1_use_ram ? ram_rdata : 8'd0;
      out_data.fill_level    <= 6'(s1_fill);
      out_data.overflow_flag <= s1_flag;
    end
  end

  // Checks
  `BRFIFO_ASSERT_NEVER(a_count_bound, clk, rst, count > DEPTH_C)
  `BRFIFO_ASSERT_NEVER(a_span_covers_count, clk, rst, span < count)
  `BRFIFO_ASSERT_NEXT(a_flag_sticky, clk, rst, error_sticky, error_sticky)

endmodule

`default_nettype wire

### tb/tb_byte_ring_fifo_with_skip.sv
// Self-checking testbench for the byte ring FIFO with push, pop, peek, skip and flush.
`timescale 1ns / 100ps

module tb_byte_ring_fifo_with_skip;
  import brfifo_pkg::*;

  localparam int DEPTH       = BRFIFO_DEPTH;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_OPS   = 180;
  localparam int NUM_PHASES  = 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  // Ops waiting to be driven and results owed by the block
  in_item_t  op_backlog[$];
  out_item_t due_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;
  int cycle_count = 0;

  // Shadow copy of the ring state
  logic [7:0] shadow_ring [DEPTH] = '{default: 8'h00};
  int         shadow_wr_ptr = 0;
  int         shadow_rd_ptr = 0;
  int         shadow_fill = 0;
  logic       shadow_err = 1'b0;
  logic       shadow_wr_en = 1'b1;

  byte_ring_fifo_with_skip dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one op to the shadow ring and return the result it owes
  function automatic out_item_t ring_op_result(input in_item_t op);
    out_item_t r;
    r = '0;
    case (op.kind)
      KIND_PUSH: begin
        if (!shadow_wr_en) begin
          r.status = STATUS_WR_OFF;
        end else if (shadow_fill >= DEPTH) begin
          shadow_err = 1'b1;
          r.status = STATUS_FULL;
        end else begin
          shadow_ring[PTR_W'(shadow_wr_ptr)] = op.data_in;
          shadow_wr_ptr = (shadow_wr_ptr + 1) % DEPTH;
          shadow_fill++;
        end
      end
      KIND_POP, KIND_PEEK: begin
        if (shadow_fill == 0) begin
          shadow_err = 1'b1;
          r.status = STATUS_TOO_FEW;
        end else begin
          r.data_out = shadow_ring[PTR_W'(shadow_rd_ptr)];
          if (op.kind == KIND_POP) begin
            shadow_rd_ptr = (shadow_rd_ptr + 1) % DEPTH;
            shadow_fill--;
          end
        end
      end
      KIND_SKIP: begin
        if (shadow_fill < int'(op.skip_count)) begin
          shadow_err = 1'b1;
          r.status = STATUS_TOO_FEW;
        end else begin
          shadow_fill -= int'(op.skip_count);
          shadow_rd_ptr = (shadow_rd_ptr + int'(op.skip_count)) % DEPTH;
          r.data_out = shadow_ring[PTR_W'(shadow_rd_ptr)];
        end
      end
      KIND_FLUSH: begin
        shadow_ring = '{default: 8'h00};
        shadow_wr_ptr = 0;
        shadow_rd_ptr = 0;
        shadow_fill = 0;
      end
      default: ;
    endcase
    r.fill_level = shadow_fill[5:0];
    r.overflow_flag = shadow_err;
    return r;
  endfunction

  function automatic in_item_t mk_op(input logic [2:0] kind, input int data, input int n);
    in_item_t op;
    op.kind = kind;
    op.data_in = data[7:0];
    op.skip_count = n[5:0];
    return op;
  endfunction

  // Mostly bursts of well-formed ops with random content, some noise
  task automatic queue_random_ops(input int target);
    int added;
    int pick;
    int len;
    added = 0;
    while (added < target) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        len = $urandom_range(1, 36);
        repeat (len) op_backlog.push_back(mk_op(KIND_PUSH, $urandom_range(255), $urandom_range(63)));
      end else if (pick < 50) begin
        len = $urandom_range(1, 36);
        repeat (len) op_backlog.push_back(mk_op(KIND_POP, $urandom_range(255), $urandom_range(63)));
      end else if (pick < 60) begin
        len = $urandom_range(1, 3);
        repeat (len) op_backlog.push_back(mk_op(KIND_PEEK, $urandom_range(255), $urandom_range(63)));
      end else if (pick < 78) begin
        len = 1;
        op_backlog.push_back(mk_op(KIND_SKIP, $urandom_range(255),
                                   ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(8)));
      end else if (pick < 83) begin
        len = 1;
        op_backlog.push_back(mk_op(KIND_FLUSH, $urandom_range(255), $urandom_range(63)));
      end else begin
        len = 1;
        op_backlog.push_back(mk_op(3'($urandom_range(7)), $urandom_range(255),
                                   $urandom_range(63)));
      end
      added += len;
    end
  endtask

  // Block until every op has been sent and every result has come back
  task automatic wait_drained();
    @(negedge clk);
    while (op_backlog.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_enable_reg(input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    shadow_wr_en = val;
    cfg_valid <= 1'b0;
  endtask

  // Drive ops; predict each one at the edge of its transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) due_results.push_back(ring_op_result(in_data));
      // hold a stalled op, otherwise present the next one or idle
      if (!in_valid || !in_stall) begin
        if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= op_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side and check each result transfer
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          err_count++;
        end else begin
          want = due_results.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_data.status);
            err_count++;
          end
          if (out_data.data_out !== want.data_out) begin
            $display("%0t: data_out expected %h actual %h", $time, want.data_out,
                     out_data.data_out);
            err_count++;
          end
          if (out_data.fill_level !== want.fill_level) begin
            $display("%0t: fill_level expected %0d actual %0d", $time, want.fill_level,
                     out_data.fill_level);
            err_count++;
          end
          if (out_data.overflow_flag !== want.overflow_flag) begin
            $display("%0t: overflow_flag expected %0d actual %0d", $time, want.overflow_flag,
                     out_data.overflow_flag);
            err_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Bail out if the run hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        wait_drained();
        repeat (4) @(posedge clk);
      end
      write_enable_reg((p % 3) != 2);
      @(negedge clk);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (p == 0) begin
        // field extremes, every kind, empty and stale-byte corners
        op_backlog.push_back(mk_op(KIND_PUSH, 'h00, 0));
        op_backlog.push_back(mk_op(KIND_PUSH, 'hFF, 63));
        op_backlog.push_back(mk_op(KIND_PUSH, 'hA5, 0));
        op_backlog.push_back(mk_op(KIND_PEEK, 'hFF, 63));
        op_backlog.push_back(mk_op(KIND_POP, 'h00, 0));
        op_backlog.push_back(mk_op(KIND_SKIP, 'h00, 0));
        op_backlog.push_back(mk_op(KIND_SKIP, 'hFF, 2));
        op_backlog.push_back(mk_op(3'd5, 'hFF, 63));
        op_backlog.push_back(mk_op(3'd6, 'h00, 0));
        op_backlog.push_back(mk_op(3'd7, 'hFF, 63));
        op_backlog.push_back(mk_op(KIND_PUSH, 'h3C, 0));
        op_backlog.push_back(mk_op(KIND_PUSH, 'hC3, 0));
        op_backlog.push_back(mk_op(KIND_FLUSH, 'hFF, 63));
        op_backlog.push_back(mk_op(KIND_PEEK, 'h00, 0));
        op_backlog.push_back(mk_op(KIND_POP, 'h00, 0));
        op_backlog.push_back(mk_op(KIND_SKIP, 'h00, 1));
        op_backlog.push_back(mk_op(KIND_SKIP, 'h00, 0));
        op_backlog.push_back(mk_op(KIND_SKIP, 'h00, 32));
        op_backlog.push_back(mk_op(KIND_SKIP, 'hFF, 63));
        op_backlog.push_back(mk_op(KIND_PUSH, 'h5A, 0));
        op_backlog.push_back(mk_op(KIND_SKIP, 'h00, 1));
        op_backlog.push_back(mk_op(KIND_FLUSH, 'h00, 0));
        op_backlog.push_back(mk_op(KIND_PUSH, 'hFF, 63));
      end
      queue_random_ops(PHASE_OPS);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
